/* hw/rtl/bps_pkg.sv */
// bps_pkg: shared constants and types for the bilinear patch sampler
// depends on nothing; used by bilinear_patch_sampler
`timescale 1ns / 1ps

package bps_pkg;

  // default sizing of the top level
  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;
  localparam int DefMaxRadius = 15;

  // fixed field widths
  localparam int PixW      = 16;
  localparam int IdxW      = 10;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int ImgWidthW = 11;
  localparam int CornerW   = 10;
  localparam int RadCfgW   = 4;
  localparam int FracW     = 16;
  localparam int WgtW      = 17;
  localparam int ProdW     = WgtW + PixW;
  localparam int SumW      = ProdW + 2;
  localparam int CoordW    = 16;

  // reset values of the configuration registers
  localparam logic [ImgWidthW-1:0] ImgWidthRst = ImgWidthW'(640);
  localparam logic [RadCfgW-1:0]   RadiusRst   = RadCfgW'(1);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth = 3'd0,
    RegCornerCol  = 3'd1,
    RegCornerRow  = 3'd2,
    RegRadius     = 3'd3,
    RegFracU      = 3'd4,
    RegFracV      = 3'd5,
    RegUseMask    = 3'd6
  } cfg_reg_e;

  // tag that travels with a result through the blend pipeline
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            last;
  } res_tag_t;

endpackage

/* hw/rtl/bilinear_patch_sampler.sv */
// Sampling a bilinear-interpolated square patch out of a raster pixel stream.
// It uses bps_pkg for constants, the register index enum and the result tag struct.
// The block takes one pixel per clock whenever the input is not stalled, with no gaps,
// whatever the configuration. A result follows the clock edge that accepts the pixel
// completing its window position. That edge does the line buffer read and the
// offset product. The following edges do four 17x16 weight multipliers, the adder
// tree with rounding, and saturation into the output register. The line buffer is
// one synchronous memory of MAX_WIDTH words that is read and written once per
// accepted pixel, at the same column, so the rate is set by that single port pair.
// The input stalls only when the output is stalled and every pipeline stage is
// full. The configuration port is always ready. A register write applies from the
// next accepted pixel on; the offsets travel with each pixel through the pipeline.
`timescale 1ns / 1ps

module bilinear_patch_sampler #(
  parameter int MAX_WIDTH  = bps_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = bps_pkg::DefMaxHeight,
  parameter int MAX_RADIUS = bps_pkg::DefMaxRadius
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0] cfg_data_i,
  // pixel input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bps_pkg::PixW-1:0]     pixel_i,
  input  logic                         frame_start_i,
  input  logic                         keep_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bps_pkg::PixW-1:0]     sample_o,
  output logic [bps_pkg::IdxW-1:0]     patch_index_o,
  output logic                         last_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int RadW = $clog2(MAX_RADIUS + 1);
  localparam int PixW = bps_pkg::PixW;
  localparam int IdxW = bps_pkg::IdxW;
  localparam int WgtW = bps_pkg::WgtW;
  localparam int ProdW = bps_pkg::ProdW;
  localparam int SumW = bps_pkg::SumW;
  localparam int CoordW = bps_pkg::CoordW;
  localparam int FracW = bps_pkg::FracW;

  // configuration registers
  logic [bps_pkg::ImgWidthW-1:0] image_width_q;
  logic [bps_pkg::CornerW-1:0]   corner_col_q, corner_row_q;
  logic [bps_pkg::RadCfgW-1:0]   radius_q;
  logic [FracW-1:0]              frac_u_q, frac_v_q;
  logic                          use_mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= bps_pkg::ImgWidthRst;
      corner_col_q  <= '0;
      corner_row_q  <= '0;
      radius_q      <= bps_pkg::RadiusRst;
      frac_u_q      <= '0;
      frac_v_q      <= '0;
      use_mask_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (bps_pkg::cfg_reg_e'(cfg_index_i))
        bps_pkg::RegImageWidth: image_width_q <= cfg_data_i[bps_pkg::ImgWidthW-1:0];
        bps_pkg::RegCornerCol:  corner_col_q  <= cfg_data_i[bps_pkg::CornerW-1:0];
        bps_pkg::RegCornerRow:  corner_row_q  <= cfg_data_i[bps_pkg::CornerW-1:0];
        bps_pkg::RegRadius:     radius_q      <= cfg_data_i[bps_pkg::RadCfgW-1:0];
        bps_pkg::RegFracU:      frac_u_q      <= cfg_data_i[FracW-1:0];
        bps_pkg::RegFracV:      frac_v_q      <= cfg_data_i[FracW-1:0];
        bps_pkg::RegUseMask:    use_mask_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // weights from the offsets captured with the pixel in stage 1
  logic [2*FracW-1:0] uv, s1_uv_q;
  logic [FracW-1:0]   s1_fu_q, s1_fv_q;
  logic [2*FracW:0]   uv_rnd;
  logic [WgtW-1:0]    w00, w01, w10, w11;
  logic [WgtW:0]      w00_wide;

  assign uv = frac_u_q * frac_v_q;

  always_comb begin
    uv_rnd   = {1'b0, s1_uv_q} + (2*FracW+1)'(32768);
    w11      = WgtW'(uv_rnd >> FracW);
    w01      = WgtW'(s1_fu_q) - w11;
    w10      = WgtW'(s1_fv_q) - w11;
    w00_wide = (WgtW+1)'(65536) - (WgtW+1)'(s1_fu_q) - (WgtW+1)'(s1_fv_q)
               + (WgtW+1)'(w11);
    w00      = w00_wide[WgtW-1:0];
  end

  // pipeline enables, output side first
  logic v1_q, v2_q, v3_q, ov_q;
  logic en_o, en3, en2, en1, in_acc;

  assign en_o   = !ov_q || !out_stall_i;
  assign en3    = !v3_q || en_o;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign in_stall_o = !en1;
  assign in_acc = in_valid_i && en1;

  // raster position and window decision for the incoming pixel
  logic [ColW:0]        col_q, col_cur, col_nxt, eff_w;
  logic [RowW-1:0]      row_q, row_cur;
  logic [RowW:0]        row_inc;
  logic [IdxW-1:0]      out_cnt_q, out_cnt_cur;
  logic                 done_q, done_cur;
  logic [RadW-1:0]      r_eff;
  logic [31:0]          iw32;
  logic signed [CoordW-1:0] x_s, y_s, cc_lo, cc_hi, cr_lo, cr_hi;
  logic                 in_win, is_final, emit;

  always_comb begin
    iw32 = 32'(image_width_q);
    if (iw32 < 32'd2) begin
      eff_w = (ColW+1)'(2);
    end else if (iw32 > 32'(MAX_WIDTH)) begin
      eff_w = (ColW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (ColW+1)'(image_width_q);
    end
    if (32'(radius_q) > 32'(MAX_RADIUS)) begin
      r_eff = RadW'(MAX_RADIUS);
    end else begin
      r_eff = RadW'(radius_q);
    end

    // frame start restarts the raster before the pixel is taken in
    col_cur     = (frame_start_i || col_q >= eff_w) ? '0 : col_q;
    row_cur     = frame_start_i ? '0 : row_q;
    out_cnt_cur = frame_start_i ? '0 : out_cnt_q;
    done_cur    = frame_start_i ? 1'b0 : done_q;

    x_s   = $signed(CoordW'(col_cur)) - $signed(CoordW'(1));
    y_s   = $signed(CoordW'(row_cur)) - $signed(CoordW'(1));
    cc_lo = $signed(CoordW'(corner_col_q)) - $signed(CoordW'(r_eff));
    cc_hi = $signed(CoordW'(corner_col_q)) + $signed(CoordW'(r_eff));
    cr_lo = $signed(CoordW'(corner_row_q)) - $signed(CoordW'(r_eff));
    cr_hi = $signed(CoordW'(corner_row_q)) + $signed(CoordW'(r_eff));

    in_win   = !done_cur && (col_cur != '0) && (row_cur != '0) &&
               (x_s >= cc_lo) && (x_s <= cc_hi) && (y_s >= cr_lo) && (y_s <= cr_hi);
    is_final = (x_s == cc_hi) && (y_s == cr_hi);
    emit     = in_win && (!use_mask_q || keep_i);

    col_nxt = col_cur + (ColW+1)'(1);
    row_inc = {1'b0, row_cur} + (RowW+1)'(1);
  end

  // raster counters and left neighbor
  logic [PixW-1:0] left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      out_cnt_q <= '0;
      done_q    <= 1'b0;
      left_q    <= '0;
    end else if (in_acc) begin
      left_q    <= pixel_i;
      out_cnt_q <= emit ? out_cnt_cur + IdxW'(1) : out_cnt_cur;
      done_q    <= done_cur || (in_win && is_final);
      if (col_nxt >= eff_w) begin
        col_q <= '0;
        row_q <= (32'(row_inc) >= 32'(MAX_HEIGHT)) ? '0 : row_inc[RowW-1:0];
      end else begin
        col_q <= col_nxt;
        row_q <= row_cur;
      end
    end
  end

  // line buffer: old value read out, new pixel written at the same column
  logic [PixW-1:0] line_mem [MAX_WIDTH];
  logic [PixW-1:0] above_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_q                 <= line_mem[col_cur[ColW-1:0]];
      line_mem[col_cur[ColW-1:0]] <= pixel_i;
    end
  end

  // stage 1: pixel waiting for its above neighbor
  logic [PixW-1:0]  s1_pix_q, s1_left_q, diag_q;
  logic             s1_emit_q;
  bps_pkg::res_tag_t s1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q      <= pixel_i;
      s1_left_q     <= left_q;
      s1_emit_q     <= emit;
      s1_tag_q.idx  <= out_cnt_cur;
      s1_tag_q.last <= is_final;
      s1_fu_q       <= frac_u_q;
      s1_fv_q       <= frac_v_q;
      s1_uv_q       <= uv;
    end
  end

  // above-left neighbor follows the line buffer output in item order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_q <= '0;
    end else if (v1_q && en2) begin
      diag_q <= above_q;
    end
  end

  // stage 2: four weighted products
  logic [ProdW-1:0] p00_q, p01_q, p10_q, p11_q;
  bps_pkg::res_tag_t s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      p00_q    <= w00 * diag_q;
      p01_q    <= w01 * above_q;
      p10_q    <= w10 * s1_left_q;
      p11_q    <= w11 * s1_pix_q;
      s2_tag_q <= s1_tag_q;
    end
  end

  // stage 3: sum with rounding
  logic [SumW-1:0] sum_q;
  bps_pkg::res_tag_t s3_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      sum_q <= SumW'(p00_q) + SumW'(p01_q) + SumW'(p10_q) + SumW'(p11_q)
               + SumW'(32768);
      s3_tag_q <= s2_tag_q;
    end
  end

  // output register with saturation
  logic [PixW-1:0] sample_q;
  logic [SumW-PixW-1:0] sum_hi;
  bps_pkg::res_tag_t out_tag_q;

  assign sum_hi = sum_q[SumW-1:PixW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && v3_q) begin
      sample_q  <= (sum_hi > (SumW-PixW)'(16'hFFFF)) ? '1 : sum_hi[PixW-1:0];
      out_tag_q <= s3_tag_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign sample_o      = sample_q;
  assign patch_index_o = out_tag_q.idx;
  assign last_o        = out_tag_q.last;

`ifndef SYNTHESIS
  // a finished patch emits nothing until the next frame start
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !frame_start_i && done_q |=> !(v1_q && s1_emit_q))
    else $error("emission after patch completion");

  // an accepted pixel always lands in stage 1
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted pixel lost before stage 1");

  // above-left neighbor takes the line buffer value of the item that left stage 1
  a_diag_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && en2 |=> diag_q == $past(above_q))
    else $error("above-left neighbor out of step");

  // a held stage 2 keeps its tag
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q && $stable(s2_tag_q))
    else $error("stage 2 changed while held");
`endif

endmodule
